/* hw/rtl/msrp_pkg.sv */
// ----------------------------------------------------------------------------
// msrp_pkg
// shared types, character codes and helpers for the motor speed reply parser
// ----------------------------------------------------------------------------
`default_nettype none

package msrp_pkg;

    localparam int BYTE_W  = 8;
    localparam int SPEED_W = 21;
    localparam int DIGIT_W = 4;

    localparam logic [BYTE_W-1:0] CH_QUESTION = 8'd63;
    localparam logic [BYTE_W-1:0] CH_S        = 8'd83;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'd13;
    localparam logic [BYTE_W-1:0] CH_EQUAL    = 8'd61;
    localparam logic [BYTE_W-1:0] CH_COLON    = 8'd58;
    localparam logic [BYTE_W-1:0] CH_MINUS    = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'd57;
    localparam logic [BYTE_W-1:0] CH_NUL      = 8'd0;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_QMARK   = 3'd1,
        PH_HDR_CR  = 3'd2,
        PH_HDR_S   = 3'd3,
        PH_HDR_EQ  = 3'd4,
        PH_PARSE   = 3'd5,
        PH_IDLE    = 3'd6
    } phase_t;

    typedef struct packed {
        logic               found;
        logic [SPEED_W-1:0] first_speed;
        logic [SPEED_W-1:0] second_speed;
    } result_t;

    // largest value of the given number of decimal digits
    function automatic logic [31:0] digit_bound(input int digits);
        logic [31:0] b;
        b = 32'd1;
        for (int i = 0; i < digits; i++)
        begin
            b = b * 32'd10;
        end
        return b - 32'd1;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/motor_speed_reply_parser.sv */
// ----------------------------------------------------------------------------
// motor_speed_reply_parser
// result path: a byte that ends a reading or a buffer goes through the input
//   register, then its result through the result register
// throughput: one byte per cycle (combinational parse) unless a result waits unread
// reset: asynchronous, clears both valid flags and returns the parser to
//   header hunting with zeroed accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_reply_parser #(
    parameter int MAX_DIGITS = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire logic        s_axis_tlast,   // buffer_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // first_speed[20:0], second_speed[41:21], zero
    output logic             m_axis_tuser    // found
);

    logic                          in_valid_reg;
    logic [msrp_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_last_reg;

    logic              advance;
    logic              has_result;
    logic              can_load;
    msrp_pkg::result_t result;
    msrp_pkg::result_t out_data;

    assign advance       = in_valid_reg && (!has_result || can_load);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    msrp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .rx_byte    (in_byte_reg),
        .buffer_end (in_last_reg),
        .has_result (has_result),
        .result     (result)
    );

    msrp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && has_result),
        .push_data (result),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {6'b000000, out_data.second_speed, out_data.first_speed};
    assign m_axis_tuser = out_data.found;

endmodule

`default_nettype wire

/* hw/rtl/msrp_parser.sv */
// ----------------------------------------------------------------------------
// msrp_parser
// header match and two-number decimal parse, one byte per advance
// ----------------------------------------------------------------------------
`default_nettype none

module msrp_parser #(
    parameter int MAX_DIGITS = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [msrp_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic                       buffer_end,
    output logic                            has_result,
    output msrp_pkg::result_t               result
);

    localparam logic [31:0] BOUND = msrp_pkg::digit_bound(MAX_DIGITS);
    localparam int          ACC_W = $clog2(BOUND + 32'd1);
    localparam int          PRD_W = ACC_W + 4;
    localparam logic [PRD_W-1:0] BOUND_X = PRD_W'(BOUND);

    msrp_pkg::phase_t   phase_reg, phase_next;
    logic [ACC_W-1:0]   first_accum_reg, first_accum_next;
    logic [ACC_W-1:0]   second_accum_reg, second_accum_next;
    logic               first_negative_reg, first_negative_next;
    logic               second_negative_reg, second_negative_next;
    logic               colon_seen_reg, colon_seen_next;

    logic                          is_term;
    logic                          emit_term;
    logic [PRD_W-1:0]              pushed;
    logic [msrp_pkg::DIGIT_W-1:0]  digit;
    logic [msrp_pkg::SPEED_W-1:0]  first_mag;
    logic [msrp_pkg::SPEED_W-1:0]  second_mag;

    assign is_term = (rx_byte == msrp_pkg::CH_CR) || (rx_byte == msrp_pkg::CH_NUL)
                     || rx_byte[msrp_pkg::BYTE_W-1];
    assign digit   = msrp_pkg::DIGIT_W'(rx_byte - msrp_pkg::CH_ZERO);
    assign pushed  = ({second_accum_reg, 3'b000} + {2'b00, second_accum_reg, 1'b0})
                     + PRD_W'(digit);

    always_comb
    begin
        phase_next           = phase_reg;
        first_accum_next     = first_accum_reg;
        second_accum_next    = second_accum_reg;
        first_negative_next  = first_negative_reg;
        second_negative_next = second_negative_reg;
        colon_seen_next      = colon_seen_reg;
        emit_term            = 1'b0;

        case (phase_reg)
            msrp_pkg::PH_HUNT:
            begin
                phase_next = (rx_byte == msrp_pkg::CH_QUESTION) ? msrp_pkg::PH_QMARK
                                                                 : msrp_pkg::PH_HUNT;
            end
            msrp_pkg::PH_QMARK:
            begin
                if (rx_byte == msrp_pkg::CH_S)
                begin
                    phase_next = msrp_pkg::PH_HDR_CR;
                end
                else
                begin
                    phase_next = (rx_byte == msrp_pkg::CH_QUESTION) ? msrp_pkg::PH_QMARK
                                                                     : msrp_pkg::PH_HUNT;
                end
            end
            msrp_pkg::PH_HDR_CR:
            begin
                phase_next = (rx_byte == msrp_pkg::CH_CR) ? msrp_pkg::PH_HDR_S
                                                           : msrp_pkg::PH_IDLE;
            end
            msrp_pkg::PH_HDR_S:
            begin
                phase_next = (rx_byte == msrp_pkg::CH_S) ? msrp_pkg::PH_HDR_EQ
                                                          : msrp_pkg::PH_IDLE;
            end
            msrp_pkg::PH_HDR_EQ:
            begin
                phase_next = (rx_byte == msrp_pkg::CH_EQUAL) ? msrp_pkg::PH_PARSE
                                                              : msrp_pkg::PH_IDLE;
            end
            msrp_pkg::PH_PARSE:
            begin
                if (is_term)
                begin
                    emit_term  = 1'b1;
                    phase_next = msrp_pkg::PH_IDLE;
                end
                else if (rx_byte == msrp_pkg::CH_COLON)
                begin
                    if (!colon_seen_reg)
                    begin
                        colon_seen_next      = 1'b1;
                        first_accum_next     = second_accum_reg;
                        first_negative_next  = second_negative_reg;
                        second_accum_next    = '0;
                        second_negative_next = 1'b0;
                    end
                end
                else if (rx_byte == msrp_pkg::CH_MINUS)
                begin
                    second_negative_next = 1'b1;
                end
                else if (rx_byte inside {[msrp_pkg::CH_ZERO:msrp_pkg::CH_NINE]})
                begin
                    second_accum_next = (pushed > BOUND_X) ? ACC_W'(BOUND)
                                                           : pushed[ACC_W-1:0];
                end
            end
            default:
            begin
                phase_next = msrp_pkg::PH_IDLE;
            end
        endcase
    end

    // reading taken from the values after this byte
    assign first_mag  = msrp_pkg::SPEED_W'(first_accum_next);
    assign second_mag = msrp_pkg::SPEED_W'(second_accum_next);

    always_comb
    begin
        has_result = emit_term || buffer_end;
        if (emit_term || (phase_next == msrp_pkg::PH_PARSE))
        begin
            result.found        = 1'b1;
            result.first_speed  = first_negative_next ? first_mag : (~first_mag + 1'b1);
            result.second_speed = second_negative_next ? (~second_mag + 1'b1) : second_mag;
        end
        else
        begin
            result.found        = 1'b0;
            result.first_speed  = '0;
            result.second_speed = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= msrp_pkg::PH_HUNT;
            first_accum_reg     <= '0;
            second_accum_reg    <= '0;
            first_negative_reg  <= 1'b0;
            second_negative_reg <= 1'b0;
            colon_seen_reg      <= 1'b0;
        end
        else if (advance)
        begin
            if (buffer_end)
            begin
                phase_reg           <= msrp_pkg::PH_HUNT;
                first_accum_reg     <= '0;
                second_accum_reg    <= '0;
                first_negative_reg  <= 1'b0;
                second_negative_reg <= 1'b0;
                colon_seen_reg      <= 1'b0;
            end
            else
            begin
                phase_reg           <= phase_next;
                first_accum_reg     <= first_accum_next;
                second_accum_reg    <= second_accum_next;
                first_negative_reg  <= first_negative_next;
                second_negative_reg <= second_negative_next;
                colon_seen_reg      <= colon_seen_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/msrp_out_stage.sv */
// ----------------------------------------------------------------------------
// msrp_out_stage
// result register toward the master-side stream
// ----------------------------------------------------------------------------
`default_nettype none

module msrp_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire msrp_pkg::result_t push_data,
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output msrp_pkg::result_t      out_data
);

    logic              valid_reg;
    msrp_pkg::result_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_speed_reply_parser testbench
// Feeds received bytes, grouped into read buffers, through the slave stream
// and checks every reply on the master stream against a cycle-free model of
// the header hunt, the two-number parse, saturation and buffer-end rules.
// A short hand-written table comes first, then random buffers, most of them
// well-formed replies with random numbers, the rest noise or broken headers.
// Both streams stall in short random bursts except near the end of the run.
// ----------------------------------------------------------------------------
module testbench;
    import msrp_pkg::*;

    localparam int DIGITS       = 6;
    localparam int DIGIT_LIMIT  = 10 ** DIGITS - 1;
    localparam int RANDOM_BYTES = 700;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    reply;
    } stim_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    stim_row_t   stim_rows[$];
    result_t     pending_replies[$];
    result_t     expected_reply;

    phase_t      speed_phase;
    logic [19:0] lead_acc;
    logic [19:0] trail_acc;
    logic        lead_neg;
    logic        trail_neg;
    logic        colon_hit;

    logic        idle_on     = 1'b1;
    int          stall_left  = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          byte_count  = 0;
    int          buffer_count = 0;
    int          found_count = 0;
    int          empty_count = 0;

    motor_speed_reply_parser #(
        .MAX_DIGITS(DIGITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic clear_parser_model();
        speed_phase = PH_HUNT;
        lead_acc    = 20'd0;
        trail_acc   = 20'd0;
        lead_neg    = 1'b0;
        trail_neg   = 1'b0;
        colon_hit   = 1'b0;
    endtask

    function automatic result_t reading_result();
        result_t     r;
        logic [20:0] lead_mag;
        logic [20:0] trail_mag;
        lead_mag       = {1'b0, lead_acc};
        trail_mag      = {1'b0, trail_acc};
        r.found        = 1'b1;
        r.first_speed  = lead_neg ? lead_mag : -lead_mag;
        r.second_speed = trail_neg ? -trail_mag : trail_mag;
        return r;
    endfunction

    task automatic predict_reply(input logic [7:0] b, input logic last,
                                 output logic hit, output result_t r);
        logic [31:0] digit_sum;
        hit = 1'b0;
        r   = '0;
        case (speed_phase)
            PH_HUNT:
                speed_phase = (b == CH_QUESTION) ? PH_QMARK : PH_HUNT;
            PH_QMARK:
                if (b == CH_S)
                    speed_phase = PH_HDR_CR;
                else
                    speed_phase = (b == CH_QUESTION) ? PH_QMARK : PH_HUNT;
            PH_HDR_CR:
                speed_phase = (b == CH_CR) ? PH_HDR_S : PH_IDLE;
            PH_HDR_S:
                speed_phase = (b == CH_S) ? PH_HDR_EQ : PH_IDLE;
            PH_HDR_EQ:
                speed_phase = (b == CH_EQUAL) ? PH_PARSE : PH_IDLE;
            PH_PARSE:
            begin
                if (b == CH_CR || b == CH_NUL || b[7])
                begin
                    r           = reading_result();
                    hit         = 1'b1;
                    speed_phase = PH_IDLE;
                end
                else if (b == CH_COLON)
                begin
                    if (!colon_hit)
                    begin
                        colon_hit = 1'b1;
                        lead_acc  = trail_acc;
                        lead_neg  = trail_neg;
                        trail_acc = 20'd0;
                        trail_neg = 1'b0;
                    end
                end
                else if (b == CH_MINUS)
                    trail_neg = 1'b1;
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    digit_sum = trail_acc * 32'd10 + 32'(b - CH_ZERO);
                    if (digit_sum > DIGIT_LIMIT)
                        digit_sum = DIGIT_LIMIT;
                    trail_acc = digit_sum[19:0];
                end
            end
            default:
                speed_phase = PH_IDLE;
        endcase
        if (last)
        begin
            if (!hit)
            begin
                if (speed_phase == PH_PARSE)
                    r = reading_result();
                hit = 1'b1;
            end
            clear_parser_model();
        end
    endtask

    task automatic add_row(input logic [7:0] data, input logic last);
        stim_row_t row;
        row       = '0;
        row.data  = data;
        row.last  = last;
        stim_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [7:0] data, input logic last, input logic found,
                             input int first, input int second);
        stim_row_t row;
        row                    = '0;
        row.data               = data;
        row.last               = last;
        row.typed              = 1'b1;
        row.reply.found        = found;
        row.reply.first_speed  = first[20:0];
        row.reply.second_speed = second[20:0];
        stim_rows.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0);
    endtask

    task automatic add_random_buffer();
        logic [7:0] bytes_q[$];
        int         n_digits;
        int         fields;
        int         term_kind;
        int         hdr_pos;
        logic       with_colon;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) bytes_q.push_back(8'($urandom));
            bytes_q.push_back(CH_QUESTION);
            bytes_q.push_back(CH_S);
            bytes_q.push_back(CH_CR);
            bytes_q.push_back(CH_S);
            bytes_q.push_back(CH_EQUAL);
            // broken header now and then
            if ($urandom_range(0, 7) == 0)
            begin
                hdr_pos = bytes_q.size() - 1 - $urandom_range(0, 4);
                bytes_q[hdr_pos] = 8'($urandom);
            end
            with_colon = ($urandom_range(0, 6) != 0);
            fields = with_colon ? 2 : 1;
            for (int f = 0; f < fields; f++)
            begin
                if ($urandom_range(0, 2) == 0)
                    bytes_q.push_back(CH_MINUS);
                n_digits = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 8)
                                                       : $urandom_range(0, 5);
                for (int d = 0; d < n_digits; d++)
                begin
                    bytes_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    if ($urandom_range(0, 11) == 0)
                        bytes_q.push_back(8'($urandom_range(97, 122)));
                end
                if ($urandom_range(0, 11) == 0)
                    bytes_q.push_back(CH_MINUS);
                if (f == 0 && with_colon)
                    bytes_q.push_back(CH_COLON);
                else if ($urandom_range(0, 9) == 0)
                    bytes_q.push_back(CH_COLON);
            end
            term_kind = $urandom_range(0, 7);
            if (term_kind < 4)
                bytes_q.push_back(CH_CR);
            else if (term_kind == 4)
                bytes_q.push_back(CH_NUL);
            else if (term_kind == 5)
                bytes_q.push_back(8'($urandom_range(128, 255)));
            if (term_kind < 6)
                repeat ($urandom_range(0, 2)) bytes_q.push_back(8'($urandom));
        end
        foreach (bytes_q[k])
            add_row(bytes_q[k], k == bytes_q.size() - 1);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("motor_speed_reply_parser regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser)
                found_count++;
            else
                empty_count++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got found %0b data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                expected_reply = pending_replies.pop_front();
                if (m_axis_tuser !== expected_reply.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, expected_reply.found, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[20:0] !== expected_reply.first_speed)
                begin
                    $display("%0t: first_speed expected %0d actual %0d", $time,
                             $signed(expected_reply.first_speed),
                             $signed(m_axis_tdata[20:0]));
                    fail_count++;
                end
                if (m_axis_tdata[41:21] !== expected_reply.second_speed)
                begin
                    $display("%0t: second_speed expected %0d actual %0d", $time,
                             $signed(expected_reply.second_speed),
                             $signed(m_axis_tdata[41:21]));
                    fail_count++;
                end
                if (m_axis_tdata[47:42] !== 6'd0)
                begin
                    $display("%0t: tdata padding expected 0 actual %h",
                             $time, m_axis_tdata[47:42]);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        stim_row_t row;
        logic      hit;
        result_t   reply;
        int        idle_end;

        clear_parser_model();

        // lone high byte as a whole buffer
        add_typed(8'hFF, 1'b1, 1'b0, 0, 0);
        // repeated question mark, extra colon, stray letter, late minus, nul end
        add_text("??S");
        add_row(CH_CR, 1'b0);
        add_text("S=-1:2:x-");
        add_typed(CH_NUL, 1'b0, 1'b1, 1, -2);
        add_typed(CH_QUESTION, 1'b1, 1'b0, 0, 0);
        // saturation, buffer ends inside the number
        add_text("?S");
        add_row(CH_CR, 1'b0);
        add_text("S=999999");
        add_typed("9", 1'b1, 1'b1, 0, DIGIT_LIMIT);

        while (stim_rows.size() < 28 + RANDOM_BYTES)
            add_random_buffer();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_end = stim_rows.size() - stim_rows.size() / 8;
        for (int i = 0; i < stim_rows.size(); i++)
        begin
            idle_on = (i < idle_end);
            row = stim_rows[i];
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= row.data;
            s_axis_tlast  <= row.last;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            predict_reply(row.data, row.last, hit, reply);
            if (row.typed)
                pending_replies.push_back(row.reply);
            else if (hit)
                pending_replies.push_back(reply);
            byte_count++;
            if (row.last)
                buffer_count++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d bytes in %0d read buffers", byte_count, buffer_count);
        $display("replies seen: %0d with a reading, %0d without", found_count, empty_count);
        if (fail_count == 0)
            $display("motor_speed_reply_parser regression: pass");
        else
            $display("motor_speed_reply_parser regression: fail");
        $finish;
    end

endmodule
